/* rtl/u8u16_pkg.sv */
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned UnitWidth  = 16;
   localparam int unsigned PointWidth = 21;
   localparam int unsigned QueueDepth = 2;
   localparam int unsigned QueuePtrW  = 1;
   localparam int unsigned QueueCntW  = 2;

   localparam logic [PointWidth-1:0] SuppBase     = 21'h010000;
   localparam logic [UnitWidth-1:0]  HighSurrBase = 16'hD800;
   localparam logic [UnitWidth-1:0]  LowSurrBase  = 16'hDC00;

   // Lead byte classes, taken from the top nibble.
   localparam logic [3:0] NibLead4  = 4'hF;
   localparam logic [3:0] NibLead3  = 4'hE;
   localparam logic [3:0] NibLead2a = 4'hC;
   localparam logic [3:0] NibLead2b = 4'hD;

   typedef logic [ByteWidth-1:0]  byte_type;
   typedef logic [UnitWidth-1:0]  unit_type;
   typedef logic [PointWidth-1:0] code_point_type;

   // Queue status: full holds off the front end, empty holds off the back end.
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

/* rtl/u8u16_if.sv */
// Channel interfaces for the byte input and the code unit output.
interface u8u16_byte_if;
   logic                valid;
   logic                ready;
   u8u16_pkg::byte_type data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface u8u16_unit_if;
   logic                valid;
   logic                ready;
   u8u16_pkg::unit_type code_unit;
   logic                last_of_run;

   modport source (output valid, output code_unit, output last_of_run, input ready);
   modport sink (input valid, input code_unit, input last_of_run, output ready);
endinterface

/* rtl/u8u16_front.sv */
// Front end: classifies UTF-8 bytes and assembles complete code points.
module u8u16_front (
   input  logic                      clock,
   input  logic                      reset,
   u8u16_byte_if.sink                req_chan,
   input  logic                      queue_full,
   output logic                      push,
   output u8u16_pkg::code_point_type push_point
);
   import u8u16_pkg::*;

   logic [1:0]     bytes_remaining_ff, bytes_remaining_in;
   code_point_type code_accum_ff, code_accum_in;
   logic           accept;
   logic [3:0]     nib;

   assign req_chan.ready = !queue_full;
   assign accept = req_chan.valid && !queue_full;
   assign nib = req_chan.data_byte[7:4];

   always_comb begin
      bytes_remaining_in = bytes_remaining_ff;
      code_accum_in = code_accum_ff;
      push = 1'b0;
      push_point = code_accum_ff;
      if (accept) begin
         if (bytes_remaining_ff == 2'd0) begin
            unique case (nib)
               NibLead4: begin
                  code_accum_in = {18'd0, req_chan.data_byte[2:0]};
                  bytes_remaining_in = 2'd3;
               end
               NibLead3: begin
                  code_accum_in = {17'd0, req_chan.data_byte[3:0]};
                  bytes_remaining_in = 2'd2;
               end
               NibLead2a, NibLead2b: begin
                  code_accum_in = {16'd0, req_chan.data_byte[4:0]};
                  bytes_remaining_in = 2'd1;
               end
               default: begin
                  code_accum_in = {13'd0, req_chan.data_byte};
                  push = 1'b1;
                  push_point = code_accum_in;
               end
            endcase
         end else begin
            // Continuation bytes are taken unchecked; only the low six bits count.
            code_accum_in = {code_accum_ff[14:0], req_chan.data_byte[5:0]};
            bytes_remaining_in = bytes_remaining_ff - 2'd1;
            push = (bytes_remaining_ff == 2'd1);
            push_point = code_accum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_remaining_ff <= 2'd0;
         code_accum_ff <= '0;
      end else begin
         bytes_remaining_ff <= bytes_remaining_in;
         code_accum_ff <= code_accum_in;
      end
   end

endmodule

/* rtl/u8u16_queue.sv */
// Two-entry queue of completed code points between the front and back ends.
module u8u16_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  u8u16_pkg::code_point_type     push_point,
   input  logic                          pop,
   output u8u16_pkg::code_point_type     pop_point,
   output u8u16_pkg::queue_status_type   status
);
   import u8u16_pkg::*;

   code_point_type         entry_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;

   assign status.empty = (count_ff == QueueCntW'(0));
   assign status.full = (count_ff == QueueCntW'(QueueDepth));
   assign pop_point = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QueuePtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QueuePtrW'(1) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QueueCntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QueueCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_point;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push) else $error("code point queue overflow");
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      status.empty |-> !pop) else $error("code point queue underflow");
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QueueCntW'(QueueDepth)) else $error("queue count out of range");
   a_ptrs_match_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == QueueCntW'(1)) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

/* rtl/u8u16_back.sv */
// Back end: turns code points into UTF-16 code units behind an output register.
module u8u16_back (
   input  logic                          clock,
   input  logic                          reset,
   input  u8u16_pkg::queue_status_type   status,
   input  u8u16_pkg::code_point_type     pop_point,
   output logic                          pop,
   u8u16_unit_if.source                  rsp_chan
);
   import u8u16_pkg::*;

   logic           out_valid_ff, out_valid_in;
   logic           pend_ff, pend_in;
   logic           last_ff, last_in;
   unit_type       unit_ff, unit_in;
   unit_type       low_ff, low_in;
   code_point_type offset;
   logic           out_free;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign offset = pop_point - SuppBase;

   always_comb begin
      out_valid_in = out_valid_ff;
      pend_in = pend_ff;
      last_in = last_ff;
      unit_in = unit_ff;
      low_in = low_ff;
      pop = 1'b0;
      if (out_free) begin
         out_valid_in = 1'b0;
         if (pend_ff) begin
            unit_in = low_ff;
            last_in = 1'b1;
            out_valid_in = 1'b1;
            pend_in = 1'b0;
         end else if (!status.empty) begin
            pop = 1'b1;
            out_valid_in = 1'b1;
            if (pop_point < SuppBase) begin
               unit_in = pop_point[UnitWidth-1:0];
               last_in = 1'b1;
            end else begin
               // The high surrogate goes out first; the low one waits in low_ff until the output is free.
               unit_in = HighSurrBase + {5'd0, offset[20:10]};
               last_in = 1'b0;
               low_in = LowSurrBase | {6'd0, offset[9:0]};
               pend_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      unit_ff <= unit_in;
      last_ff <= last_in;
      low_ff <= low_in;
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.code_unit = unit_ff;
   assign rsp_chan.last_of_run = last_ff;

   a_pend_has_high: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (out_valid_ff && !last_ff))
      else $error("pending low surrogate without a high surrogate in flight");
   a_low_follows: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && out_free) |=> (out_valid_ff && last_ff && !pend_ff))
      else $error("low surrogate not issued after high surrogate");
   a_no_pop_while_pend: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !pop) else $error("new code point taken before low surrogate");

endmodule

/* rtl/utf8_to_utf16_transcoder.sv */
// Top level of the UTF-8 to UTF-16 transcoder.
//
// Usage: bytes of a UTF-8 stream enter on req_chan, one per transaction.
// UTF-16 code units leave on rsp_chan together with last_of_run, which is
// set on the final unit of each code point. No validation is done: stray
// continuation bytes pass as single code points and continuation bytes are
// taken without checking their top bits.
// Throughput: one byte per cycle while the queue is not full. A code point
// of 0x10000 or above yields a high and then a low surrogate. The two-entry
// code point queue can fill while the low surrogate goes out when the
// following bytes complete code points back to back, and then the input
// stalls until an entry is popped; a ready receiver never stalls it otherwise.
// A completed code point passes through the queue and the output register
// before rsp_chan shows it; the low surrogate follows once the output is free.
// Reset clears the partial sequence, the queue and the output register.
// When the receiver holds rsp_chan.ready low, the output register holds its
// unit, the queue fills, and then req_chan.ready drops.
module utf8_to_utf16_transcoder (
   input  logic          clock,
   input  logic          reset,
   u8u16_byte_if.sink    req_chan,
   u8u16_unit_if.source  rsp_chan
);
   import u8u16_pkg::*;

   logic             push;
   logic             pop;
   code_point_type   push_point;
   code_point_type   pop_point;
   queue_status_type status;

   u8u16_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (status.full),
      .push       (push),
      .push_point (push_point)
   );

   u8u16_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_point (push_point),
      .pop        (pop),
      .pop_point  (pop_point),
      .status     (status)
   );

   u8u16_back u_back (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .pop_point (pop_point),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

/* dv/tb_utf8_to_utf16_transcoder.sv */
// Self-checking testbench for the UTF-8 to UTF-16 transcoder.
module tb_utf8_to_utf16_transcoder;
   import u8u16_pkg::*;

   typedef struct packed {
      unit_type code_unit;
      logic     last_of_run;
   } unit_result_type;

   logic clock = 1'b0;
   logic reset;

   u8u16_byte_if byte_chan ();
   u8u16_unit_if unit_chan ();

   utf8_to_utf16_transcoder u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (byte_chan),
      .rsp_chan (unit_chan)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Decoder state kept alongside the block.
   logic [1:0]      seq_left = 2'd0;
   code_point_type  seq_acc  = '0;
   unit_result_type expected_units[$];
   int unsigned     bytes_sent     = 0;
   int unsigned     mismatch_count = 0;
   bit              no_gaps        = 1'b0;

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic void push_code_point(input code_point_type cp);
      code_point_type offset;
      if (cp < SuppBase) begin
         expected_units.push_back('{code_unit: cp[UnitWidth-1:0], last_of_run: 1'b1});
      end else begin
         // Code points past 0x10FFFF still go through the same surrogate math.
         offset = cp - SuppBase;
         expected_units.push_back('{code_unit: unit_type'(offset >> 10) + HighSurrBase,
                                    last_of_run: 1'b0});
         expected_units.push_back('{code_unit: {6'd0, offset[9:0]} + LowSurrBase,
                                    last_of_run: 1'b1});
      end
   endfunction

   function automatic void transcode_byte(input byte_type b);
      logic [3:0] nib;
      nib = b[7:4];
      if (seq_left == 2'd0) begin
         if (nib == NibLead4) begin
            seq_acc  = code_point_type'(b[2:0]);
            seq_left = 2'd3;
         end else if (nib == NibLead3) begin
            seq_acc  = code_point_type'(b[3:0]);
            seq_left = 2'd2;
         end else if (nib == NibLead2a || nib == NibLead2b) begin
            seq_acc  = code_point_type'(b[4:0]);
            seq_left = 2'd1;
         end else begin
            seq_acc = code_point_type'(b);
            push_code_point(seq_acc);
         end
      end else begin
         // Continuation bytes are never checked; only the low six bits count.
         seq_acc  = {seq_acc[PointWidth-7:0], b[5:0]};
         seq_left = seq_left - 2'd1;
         if (seq_left == 2'd0)
            push_code_point(seq_acc);
      end
   endfunction

   task automatic send_byte(input byte_type b);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 18);
      @(negedge clock);
      if (gap > 0) begin
         byte_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      byte_chan.valid     <= 1'b1;
      byte_chan.data_byte <= b;
      do @(posedge clock); while (!byte_chan.ready);
      transcode_byte(b);
      bytes_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      byte_chan.valid <= 1'b0;
      while (expected_units.size() != 0)
         @(posedge clock);
   endtask

   function automatic byte_type continuation_byte();
      if ($urandom_range(0, 9) == 0)
         return byte_type'($urandom);
      return {2'b10, 6'($urandom)};
   endfunction

   task automatic send_random_sequence();
      int kind;
      int tail;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         if ($urandom_range(0, 99) < 85)
            send_byte({1'b0, 7'($urandom)});
         else
            send_byte({2'b10, 6'($urandom)});
         return;
      end
      if (kind >= 92) begin
         repeat ($urandom_range(1, 3))
            send_byte(byte_type'($urandom));
         return;
      end
      if (kind < 50) begin
         send_byte({3'b110, 5'($urandom)});
         tail = 1;
      end else if (kind < 70) begin
         send_byte({4'b1110, 4'($urandom)});
         tail = 2;
      end else begin
         send_byte({4'b1111, 4'($urandom)});
         tail = 3;
      end
      // Now and then cut a sequence short so the next lead lands mid sequence.
      if ($urandom_range(0, 19) == 0)
         tail = tail - 1;
      repeat (tail)
         send_byte(continuation_byte());
   endtask

   task automatic test_single_byte_points();
      send_byte(8'h00);
      send_byte(8'h7F);
      send_byte(8'h80);
      send_byte(8'hBF);
   endtask

   task automatic test_two_byte_sequences();
      send_byte(8'hC2);
      send_byte(8'hA9);
      send_byte(8'hDF);
      send_byte(8'hFF);
   endtask

   task automatic test_three_byte_sequences();
      send_byte(8'hEF);
      send_byte(8'hBF);
      send_byte(8'hBF);
      // Encodes a lone surrogate, which passes through unchanged.
      send_byte(8'hED);
      send_byte(8'hA0);
      send_byte(8'h80);
   endtask

   task automatic test_four_byte_sequences();
      send_byte(8'hF0);
      send_byte(8'h9F);
      send_byte(8'h98);
      send_byte(8'h80);
      send_byte(8'hF7);
      send_byte(8'hBF);
      send_byte(8'hBF);
      send_byte(8'hBF);
      // An F8..FF lead with malformed continuations gives an oversized code point.
      send_byte(8'hFF);
      send_byte(8'h7F);
      send_byte(8'h3F);
      send_byte(8'hC0);
   endtask

   task automatic test_pause_until_drained();
      no_gaps = 1'b1;
      repeat (6) begin
         send_byte({4'b1111, 4'($urandom)});
         repeat (3)
            send_byte({2'b10, 6'($urandom)});
         send_byte({1'b0, 7'($urandom)});
         wait_drained();
      end
      no_gaps = 1'b0;
   endtask

   task automatic test_random_stream();
      int unsigned target;
      target = bytes_sent + 1700;
      while (bytes_sent < target) begin
         if ($urandom_range(0, 39) == 0)
            no_gaps = !no_gaps;
         send_random_sequence();
      end
      no_gaps = 1'b0;
   endtask

   // Receiver side: a random stall before each transaction, none while no_gaps is set.
   initial begin : rsp_pacing
      int stall;
      unit_chan.ready = 1'b0;
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 18);
         @(negedge clock);
         if (stall > 0) begin
            unit_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         unit_chan.ready <= 1'b1;
         do @(posedge clock); while (!(unit_chan.valid && unit_chan.ready));
      end
   end

   always @(posedge clock) begin : unit_check
      unit_result_type want;
      if (!reset && unit_chan.valid && unit_chan.ready) begin
         if (expected_units.size() == 0) begin
            report_mismatch($sformatf("unexpected code unit %h", unit_chan.code_unit));
         end else begin
            want = expected_units.pop_front();
            if (unit_chan.code_unit !== want.code_unit)
               report_mismatch($sformatf("code_unit expected %h got %h",
                                         want.code_unit, unit_chan.code_unit));
            if (unit_chan.last_of_run !== want.last_of_run)
               report_mismatch($sformatf("last_of_run expected %b got %b for unit %h",
                                         want.last_of_run, unit_chan.last_of_run,
                                         want.code_unit));
         end
      end
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      reset               = 1'b1;
      byte_chan.valid     = 1'b0;
      byte_chan.data_byte = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_single_byte_points();
      test_two_byte_sequences();
      test_three_byte_sequences();
      test_four_byte_sequences();
      test_pause_until_drained();
      test_random_stream();

      @(negedge clock);
      byte_chan.valid <= 1'b0;
      while (expected_units.size() != 0)
         @(posedge clock);
      // Let any stray unit surface before the verdict.
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

/* filelist.f */
rtl/u8u16_pkg.sv
rtl/u8u16_if.sv
rtl/u8u16_front.sv
rtl/u8u16_queue.sv
rtl/u8u16_back.sv
rtl/utf8_to_utf16_transcoder.sv
dv/tb_utf8_to_utf16_transcoder.sv
